>>> rtl/bls_pkg.sv
package bls_pkg;

    // Opcodes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // Screen size after reset.
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Octant cases of a line once x has been made non-decreasing.
    typedef enum logic [1:0] {
        SHALLOW_RISE = 2'd0,
        STEEP_RISE   = 2'd1,
        STEEP_FALL   = 2'd2,
        SHALLOW_FALL = 2'd3
    } octant_t;

    // Decision of the load logic handed to the stepping state.
    typedef struct packed {
        logic    accept;
        octant_t octant;
    } load_ctrl_t;

endpackage

>>> rtl/bls_in_if.sv
interface bls_in_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS:0]   start_x;
    logic signed [COORD_BITS:0]   start_y;
    logic signed [COORD_BITS:0]   end_x;
    logic signed [COORD_BITS:0]   end_y;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

>>> rtl/bls_out_if.sv
interface bls_out_if #(
    parameter int COORD_BITS = 12
);
    logic                    valid;
    logic                    ready;
    logic                    line_accepted;
    logic                    pixel_valid;
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic                    last_pixel;

    modport source (
        output valid, line_accepted, pixel_valid, pixel_x, pixel_y, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, line_accepted, pixel_valid, pixel_x, pixel_y, last_pixel,
        output ready
    );
endinterface

>>> rtl/bls_load_calc.sv
module bls_load_calc #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]   screen_width,
    input  logic [COORD_BITS-1:0]   screen_height,
    input  logic signed [COORD_BITS:0] start_x,
    input  logic signed [COORD_BITS:0] start_y,
    input  logic signed [COORD_BITS:0] end_x,
    input  logic signed [COORD_BITS:0] end_y,
    output bls_pkg::load_ctrl_t     ctrl,
    output logic signed [COORD_BITS:0] delta_x,
    output logic signed [COORD_BITS:0] delta_y,
    output logic [COORD_BITS-1:0]   first_x,
    output logic [COORD_BITS-1:0]   first_y,
    output logic [COORD_BITS-1:0]   major_end
);

    logic signed [COORD_BITS:0] width_s;
    logic signed [COORD_BITS:0] height_s;
    logic                       start_ok;
    logic                       end_ok;
    logic                       swap;
    logic signed [COORD_BITS:0] x0;
    logic signed [COORD_BITS:0] y0;
    logic signed [COORD_BITS:0] x1;
    logic signed [COORD_BITS:0] y1;
    logic signed [COORD_BITS:0] neg_dy;

    assign width_s  = $signed({1'b0, screen_width});
    assign height_s = $signed({1'b0, screen_height});

    // Both endpoints must sit strictly inside the screen.
    assign start_ok = !start_x[COORD_BITS] && (start_x != '0) && (start_x < width_s) &&
                      !start_y[COORD_BITS] && (start_y != '0) && (start_y < height_s);
    assign end_ok   = !end_x[COORD_BITS] && (end_x != '0) && (end_x < width_s) &&
                      !end_y[COORD_BITS] && (end_y != '0) && (end_y < height_s);

    // Order the endpoints so that x does not decrease along the line.
    assign swap = start_x > end_x;
    assign x0   = swap ? end_x   : start_x;
    assign y0   = swap ? end_y   : start_y;
    assign x1   = swap ? start_x : end_x;
    assign y1   = swap ? start_y : end_y;

    assign delta_x = x1 - x0;
    assign delta_y = y1 - y0;
    assign neg_dy  = -delta_y;

    always_comb
    begin
        ctrl.accept = start_ok && end_ok;
        if (!delta_y[COORD_BITS] && (delta_x >= delta_y))
        begin
            ctrl.octant = bls_pkg::SHALLOW_RISE;
        end
        else if (delta_y >= delta_x)
        begin
            ctrl.octant = bls_pkg::STEEP_RISE;
        end
        else if (neg_dy >= delta_x)
        begin
            ctrl.octant = bls_pkg::STEEP_FALL;
        end
        else
        begin
            ctrl.octant = bls_pkg::SHALLOW_FALL;
        end
    end

    assign first_x   = x0[COORD_BITS-1:0];
    assign first_y   = y0[COORD_BITS-1:0];
    assign major_end = ((ctrl.octant == bls_pkg::SHALLOW_RISE) ||
                        (ctrl.octant == bls_pkg::SHALLOW_FALL)) ?
                       x1[COORD_BITS-1:0] : y1[COORD_BITS-1:0];

endmodule

>>> rtl/bls_core.sv
module bls_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic                       opcode,
    input  logic signed [COORD_BITS:0] start_x,
    input  logic signed [COORD_BITS:0] start_y,
    input  logic signed [COORD_BITS:0] end_x,
    input  logic signed [COORD_BITS:0] end_y,
    input  logic [COORD_BITS-1:0]      screen_width,
    input  logic [COORD_BITS-1:0]      screen_height,
    output logic                       line_accepted,
    output logic                       pixel_valid,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       last_pixel
);

    localparam int ERR_BITS = COORD_BITS + 2;
    localparam int SUM_BITS = COORD_BITS + 4;

    bls_pkg::load_ctrl_t        ld_ctrl;
    logic signed [COORD_BITS:0] ld_dx;
    logic signed [COORD_BITS:0] ld_dy;
    logic [COORD_BITS-1:0]      ld_x;
    logic [COORD_BITS-1:0]      ld_y;
    logic [COORD_BITS-1:0]      ld_major_end;

    logic                         line_active_reg;
    logic [COORD_BITS-1:0]        cursor_x_reg;
    logic [COORD_BITS-1:0]        cursor_y_reg;
    logic [COORD_BITS-1:0]        major_end_reg;
    logic signed [ERR_BITS-1:0]   error_reg;
    logic signed [COORD_BITS:0]   delta_x_reg;
    logic signed [COORD_BITS:0]   delta_y_reg;
    bls_pkg::octant_t             octant_reg;

    logic                         line_active_next;
    logic [COORD_BITS-1:0]        cursor_x_next;
    logic [COORD_BITS-1:0]        cursor_y_next;
    logic [COORD_BITS-1:0]        major_end_next;
    logic signed [ERR_BITS-1:0]   error_next;
    logic signed [COORD_BITS:0]   delta_x_next;
    logic signed [COORD_BITS:0]   delta_y_next;
    bls_pkg::octant_t             octant_next;

    logic                         is_last;
    logic signed [SUM_BITS-1:0]   err_w;
    logic signed [SUM_BITS-1:0]   dx_w;
    logic signed [SUM_BITS-1:0]   dy_w;
    logic signed [SUM_BITS-1:0]   sum_w;
    logic signed [SUM_BITS-1:0]   new_err;
    logic [COORD_BITS-1:0]        adv_x;
    logic [COORD_BITS-1:0]        adv_y;

    bls_load_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_load_calc (
        .screen_width  (screen_width),
        .screen_height (screen_height),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .ctrl          (ld_ctrl),
        .delta_x       (ld_dx),
        .delta_y       (ld_dy),
        .first_x       (ld_x),
        .first_y       (ld_y),
        .major_end     (ld_major_end)
    );

    assign is_last = ((octant_reg == bls_pkg::SHALLOW_RISE) ||
                      (octant_reg == bls_pkg::SHALLOW_FALL)) ?
                     (cursor_x_reg == major_end_reg) : (cursor_y_reg == major_end_reg);

    assign err_w = SUM_BITS'(error_reg);
    assign dx_w  = SUM_BITS'(delta_x_reg);
    assign dy_w  = SUM_BITS'(delta_y_reg);

    // One Bresenham step: an add on the error term, one compare, and a minor-axis correction.
    always_comb
    begin
        adv_x = cursor_x_reg;
        adv_y = cursor_y_reg;
        unique case (octant_reg)
            bls_pkg::SHALLOW_RISE:
            begin
                sum_w = err_w + dy_w;
                if ((sum_w <<< 1) < dx_w)
                begin
                    new_err = sum_w;
                end
                else
                begin
                    new_err = sum_w - dx_w;
                    adv_y   = cursor_y_reg + 1'b1;
                end
                adv_x = cursor_x_reg + 1'b1;
            end
            bls_pkg::STEEP_RISE:
            begin
                sum_w = err_w + dx_w;
                if ((sum_w <<< 1) < dy_w)
                begin
                    new_err = sum_w;
                end
                else
                begin
                    new_err = sum_w - dy_w;
                    adv_x   = cursor_x_reg + 1'b1;
                end
                adv_y = cursor_y_reg + 1'b1;
            end
            bls_pkg::STEEP_FALL:
            begin
                sum_w = err_w + dx_w;
                if ((sum_w <<< 1) < -dy_w)
                begin
                    new_err = sum_w;
                end
                else
                begin
                    new_err = sum_w + dy_w;
                    adv_x   = cursor_x_reg + 1'b1;
                end
                adv_y = cursor_y_reg - 1'b1;
            end
            default:
            begin
                sum_w = err_w + dy_w;
                if ((sum_w <<< 1) > -dx_w)
                begin
                    new_err = sum_w;
                end
                else
                begin
                    new_err = sum_w + dx_w;
                    adv_y   = cursor_y_reg - 1'b1;
                end
                adv_x = cursor_x_reg + 1'b1;
            end
        endcase
    end

    always_comb
    begin
        line_active_next = line_active_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        major_end_next   = major_end_reg;
        error_next       = error_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        octant_next      = octant_reg;

        line_accepted = 1'b0;
        pixel_valid   = 1'b0;
        pixel_x       = '0;
        pixel_y       = '0;
        last_pixel    = 1'b0;

        if (opcode == bls_pkg::OP_LOAD)
        begin
            line_accepted    = ld_ctrl.accept;
            line_active_next = ld_ctrl.accept;
            if (ld_ctrl.accept)
            begin
                cursor_x_next  = ld_x;
                cursor_y_next  = ld_y;
                major_end_next = ld_major_end;
                error_next     = '0;
                delta_x_next   = ld_dx;
                delta_y_next   = ld_dy;
                octant_next    = ld_ctrl.octant;
            end
        end
        else if (line_active_reg)
        begin
            pixel_valid = 1'b1;
            pixel_x     = cursor_x_reg;
            pixel_y     = cursor_y_reg;
            last_pixel  = is_last;
            if (is_last)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                cursor_x_next = adv_x;
                cursor_y_next = adv_y;
                error_next    = new_err[ERR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            major_end_reg   <= '0;
            error_reg       <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            octant_reg      <= bls_pkg::SHALLOW_RISE;
        end
        else if (fire)
        begin
            line_active_reg <= line_active_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            major_end_reg   <= major_end_next;
            error_reg       <= error_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            octant_reg      <= octant_next;
        end
    end

    // The line ends right after its last pixel is handed out.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (opcode == bls_pkg::OP_STEP) && line_active_reg && is_last)
        |=> !line_active_reg)
        else $error("line still active after last pixel");

    // A load leaves the line active exactly when its endpoints were accepted.
    a_load_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (opcode == bls_pkg::OP_LOAD))
        |=> (line_active_reg == $past(ld_ctrl.accept)))
        else $error("line state does not follow load decision");

    // Every accepted load restarts the error term.
    a_load_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (opcode == bls_pkg::OP_LOAD) && ld_ctrl.accept)
        |=> (error_reg == '0))
        else $error("error term not cleared on load");

endmodule

>>> rtl/bresenham_line_stepper.sv
// Integer Bresenham line stepper. A load word (opcode 0) carries two endpoints;
// the line starts only if both lie strictly inside the screen set by the
// screen_width and screen_height registers, and the result word reports that in
// line_accepted. Each step word (opcode 1) then returns one pixel of the line,
// starting at the endpoint with the smaller x, with last_pixel set on the final
// one; a step word while no line is active returns pixel_valid low. Every input
// word yields exactly one result word. The block takes one word per clock and
// delivers one result per clock while out_ch.ready is high: a word waits in
// the input register, where the load checks or one error-term add and compare
// decide the next line state, and its result is captured in the output register
// as the word leaves. The output register lets a new word enter while a finished
// result waits to be taken. Configuration writes are meant to happen while no
// word is in flight.
module bresenham_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bls_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_data,
    bls_in_if.sink                                in_ch,
    bls_out_if.source                             out_ch
);

    // Screen size registers.
    logic [COORD_BITS-1:0] screen_width_reg;
    logic [COORD_BITS-1:0] screen_height_reg;

    // Input register: the word being worked on this cycle.
    logic                       in_valid_reg;
    logic                       opcode_reg;
    logic signed [COORD_BITS:0] start_x_reg;
    logic signed [COORD_BITS:0] start_y_reg;
    logic signed [COORD_BITS:0] end_x_reg;
    logic signed [COORD_BITS:0] end_y_reg;

    // Output register holding the finished result word.
    logic                  out_valid_reg;
    logic                  line_accepted_reg;
    logic                  pixel_valid_reg;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic                  last_pixel_reg;

    // Result of the word in the input register.
    logic                  res_line_accepted;
    logic                  res_pixel_valid;
    logic [COORD_BITS-1:0] res_pixel_x;
    logic [COORD_BITS-1:0] res_pixel_y;
    logic                  res_last_pixel;

    logic in_fire;
    logic work_fire;

    // The working word moves on whenever the output register is free or
    // is being emptied this cycle; the input register refills in the same cycle.
    assign work_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || work_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= COORD_BITS'(bls_pkg::WIDTH_RESET);
            screen_height_reg <= COORD_BITS'(bls_pkg::HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bls_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                bls_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg  <= in_ch.opcode;
            start_x_reg <= in_ch.start_x;
            start_y_reg <= in_ch.start_y;
            end_x_reg   <= in_ch.end_x;
            end_y_reg   <= in_ch.end_y;
        end
    end

    bls_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (work_fire),
        .opcode        (opcode_reg),
        .start_x       (start_x_reg),
        .start_y       (start_y_reg),
        .end_x         (end_x_reg),
        .end_y         (end_y_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .line_accepted (res_line_accepted),
        .pixel_valid   (res_pixel_valid),
        .pixel_x       (res_pixel_x),
        .pixel_y       (res_pixel_y),
        .last_pixel    (res_last_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (work_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_fire)
        begin
            line_accepted_reg <= res_line_accepted;
            pixel_valid_reg   <= res_pixel_valid;
            pixel_x_reg       <= res_pixel_x;
            pixel_y_reg       <= res_pixel_y;
            last_pixel_reg    <= res_last_pixel;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.line_accepted = line_accepted_reg;
    assign out_ch.pixel_valid   = pixel_valid_reg;
    assign out_ch.pixel_x       = pixel_x_reg;
    assign out_ch.pixel_y       = pixel_y_reg;
    assign out_ch.last_pixel    = last_pixel_reg;

    // A result word is either a load answer or a pixel, never both.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_accepted_reg) |-> !pixel_valid_reg)
        else $error("result marks both an accepted line and a pixel");

    // An empty input register never holds off the source.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty input register");

    // A word that leaves the input register always lands in the output register.
    a_word_lands: assert property (@(posedge clk) disable iff (!rst_n)
        work_fire |=> out_valid_reg)
        else $error("processed word lost before the output register");

endmodule
